// ===== rtl/ccs_pkg.sv =====
// Shared types and constants for the C comment stripper.
// Used by the front, queue and back modules and by the top level.
package ccs_pkg;

  localparam int unsigned COUNT_BITS_DEF  = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned REPORT_W        = 32;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;

  typedef enum logic [2:0] {
    MODE_NORMAL     = 3'd0,
    MODE_SLASH      = 3'd1,
    MODE_BLOCK      = 3'd2,
    MODE_BLOCK_STAR = 3'd3,
    MODE_LINE       = 3'd4
  } scan_mode_t;

  // One queue entry carries all results caused by one input item.
  typedef struct packed {
    logic [7:0]          byte0;
    logic [7:0]          byte1;
    logic                two;     // a second result follows the first
    logic                valid0;  // first result carries a kept byte
    logic                last;    // final result of the text is in this entry
    logic [REPORT_W-1:0] count;
  } ccs_entry_t;

endpackage

// ===== rtl/ccs_front.sv =====
// Front part: accepts source bytes, runs the comment scanner and the
// removed-byte counter, and writes the results of each byte to the queue.
// Depends on ccs_pkg.
module ccs_front #(
  parameter int unsigned COUNT_BITS = ccs_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tlast,
  input  logic                q_full,
  output logic                q_push,
  output ccs_pkg::ccs_entry_t q_din
);
  import ccs_pkg::*;

  localparam logic [COUNT_BITS-1:0] CAP = {COUNT_BITS{1'b1}};

  scan_mode_t            mode_r, mode_nxt;
  logic [COUNT_BITS-1:0] total_r, total_nxt, total_add;
  logic [1:0]            add_n;
  logic [1:0]            n_res;
  logic [7:0]            b0, b1;
  logic                  v0;
  scan_mode_t            mode_scan;
  logic                  accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      total_r <= '0;
    end else begin
      mode_r  <= mode_nxt;
      total_r <= total_nxt;
    end
  end

  always_comb begin
    add_n     = 2'd0;
    n_res     = 2'd0;
    b0        = 8'h00;
    b1        = 8'h00;
    v0        = 1'b1;
    mode_scan = mode_r;
    unique case (mode_r)
      MODE_SLASH: begin
        if (in_tdata == CH_STAR) begin
          add_n     = 2'd2;
          mode_scan = MODE_BLOCK;
        end else if (in_tdata == CH_SLASH) begin
          add_n     = 2'd2;
          mode_scan = MODE_LINE;
        end else begin
          n_res     = 2'd2;
          b0        = CH_SLASH;
          b1        = in_tdata;
          mode_scan = MODE_NORMAL;
        end
      end
      MODE_BLOCK: begin
        add_n = 2'd1;
        if (in_tdata == CH_STAR) mode_scan = MODE_BLOCK_STAR;
      end
      MODE_BLOCK_STAR: begin
        add_n = 2'd1;
        if (in_tdata == CH_SLASH) mode_scan = MODE_NORMAL;
        else if (in_tdata != CH_STAR) mode_scan = MODE_BLOCK;
      end
      MODE_LINE: begin
        if (in_tdata == CH_NEWLINE) begin
          n_res     = 2'd1;
          b0        = in_tdata;
          mode_scan = MODE_NORMAL;
        end else begin
          add_n = 2'd1;
        end
      end
      default: begin
        if (in_tdata == CH_SLASH) mode_scan = MODE_SLASH;
        else begin
          n_res = 2'd1;
          b0    = in_tdata;
        end
      end
    endcase

    // End of text: a held slash can only come from normal text, so no
    // result is pending yet when it is flushed.
    if (in_tlast) begin
      if (mode_scan == MODE_SLASH) begin
        n_res = 2'd1;
        b0    = CH_SLASH;
      end
      if (n_res == 2'd0) begin
        n_res = 2'd1;
        b0    = 8'h00;
        v0    = 1'b0;
      end
    end

    if (total_r > CAP - COUNT_BITS'(add_n)) total_add = CAP;
    else total_add = total_r + COUNT_BITS'(add_n);

    mode_nxt  = mode_r;
    total_nxt = total_r;
    if (accept) begin
      if (in_tlast) begin
        mode_nxt  = MODE_NORMAL;
        total_nxt = '0;
      end else begin
        mode_nxt  = mode_scan;
        total_nxt = total_add;
      end
    end

    q_push       = accept && (n_res != 2'd0);
    q_din.byte0  = b0;
    q_din.byte1  = b1;
    q_din.two    = (n_res == 2'd2);
    q_din.valid0 = v0;
    q_din.last   = in_tlast;
    q_din.count  = REPORT_W'(total_add);
  end

endmodule

// ===== rtl/ccs_queue.sv =====
// Short queue between the front and back parts of the comment stripper.
// Register-based, one push unless full and one pop unless empty per cycle. Depends on ccs_pkg.
module ccs_queue #(
  parameter int unsigned DEPTH = ccs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  ccs_pkg::ccs_entry_t din,
  input  logic                pop,
  output logic                empty,
  output ccs_pkg::ccs_entry_t dout
);
  import ccs_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ccs_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end

endmodule

// ===== rtl/ccs_back.sv =====
// Back part: takes queue entries apart into single results and holds each
// in the output register until the sink takes it. Depends on ccs_pkg.
module ccs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  ccs_pkg::ccs_entry_t q_dout,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [39:0]         out_tdata,
  output logic                out_tuser,
  output logic                out_tlast
);
  import ccs_pkg::*;

  logic                out_valid_r, out_valid_nxt;
  logic                sel_r, sel_nxt;
  logic                load;
  logic [7:0]          byte_r;
  logic                user_r, last_r;
  logic [REPORT_W-1:0] count_r;

  assign load = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    sel_nxt       = sel_r;
    q_pop         = 1'b0;
    if (load) begin
      out_valid_nxt = !q_empty;
      if (!q_empty) begin
        // The second half of a two-result entry is sent on the next load.
        if (!sel_r && q_dout.two) begin
          sel_nxt = 1'b1;
        end else begin
          sel_nxt = 1'b0;
          q_pop   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      byte_r  <= sel_r ? q_dout.byte1 : q_dout.byte0;
      user_r  <= sel_r ? 1'b1 : q_dout.valid0;
      last_r  <= q_dout.last && (sel_r || !q_dout.two);
      count_r <= q_dout.count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {count_r, byte_r};
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

// ===== rtl/c_comment_stripper_top.sv =====
// C comment stripper. Source bytes enter one per cycle, while the queue has
// room, on the in_ channel and leave on the out_ channel with block and line
// comments removed; the newline closing a line comment is kept. A lone slash
// is held until the next byte and then sent with it, so that byte yields two
// results, sent one after the other; every other byte yields at most one
// result, and a byte marked last always yields at least one (empty if nothing
// is kept), marked with out_tlast, after which the scanner starts fresh. The
// front takes a byte in the cycle it arrives and its results pass through the
// queue and the output register; the queue (four deep by default) lets input
// keep flowing while the output stalls. out_tdata[39:8] carries the saturating
// count of removed bytes. Depends on ccs_pkg, ccs_front, ccs_queue, ccs_back.
module c_comment_stripper_top #(
  parameter int unsigned COUNT_BITS  = ccs_pkg::COUNT_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = ccs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] out_byte, [39:8] removed_count
  output logic        out_tuser,  // [0] byte_valid
  output logic        out_tlast   // last_of_text
);
  import ccs_pkg::*;

  ccs_entry_t q_din, q_dout;
  logic       q_empty, q_pop, q_push, q_full;

  ccs_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  ccs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .full   (q_full),
    .din    (q_din),
    .pop    (q_pop),
    .empty  (q_empty),
    .dout   (q_dout)
  );

  ccs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_dout     (q_dout),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/ccs_checker.sv =====
// Port-level checks for the C comment stripper top level.
// Bound to c_comment_stripper_top; needs no other file.
module ccs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("out item changed while stalled");

  // An empty result only closes a text and carries a zero byte.
  a_empty_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && (out_tdata[7:0] == 8'h00))
    else $error("empty item that is not the final one");

  // Within one text the removed count never goes down.
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast ##1 out_tvalid |->
      out_tdata[39:8] >= $past(out_tdata[39:8]))
    else $error("removed count decreased within a text");

endmodule

bind c_comment_stripper_top ccs_checker u_ccs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
